>>> hw/rtl/sist_pkg.sv
// sist_pkg: shared constants, operation codes and beat types for the sorted id set table
// no dependencies; used by sist_cell and sorted_id_set_table_unit

package sist_pkg;

    localparam int SET_DEPTH = 8;
    localparam int ID_WIDTH  = 16;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_TOGGLE = 2'd2;
    localparam logic [1:0] OP_TEST   = 2'd3;

    typedef logic [ID_WIDTH-1:0] id_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef struct packed {
        logic [1:0] operation;
        id_t        bit_id;
    } req_t;

    typedef struct packed {
        logic success;
        logic overflow;
        cnt_t entry_count;
    } rsp_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        id_t  id;
        logic ins;
        logic rem;
    } cell_cmd_t;

endpackage

>>> hw/rtl/sist_cell.sv
// sist_cell: one entry of the sorted chain, compares against the broadcast id and shifts
// depends on sist_pkg

module sist_cell
(
    input  logic                clk,
    input  sist_pkg::cell_cmd_t cmd,
    input  logic                in_use,
    input  logic                left_lt,
    input  sist_pkg::id_t       left_entry,
    input  sist_pkg::id_t       right_entry,
    output sist_pkg::id_t       entry,
    output logic                lt,
    output logic                eq
);

    sist_pkg::id_t entry_reg;
    sist_pkg::id_t entry_next;

    always_comb
    begin
        lt = in_use && (entry_reg < cmd.id);
        eq = in_use && (entry_reg == cmd.id);
    end

    // cells below the insert or remove point keep their entry
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !lt)
        begin
            entry_next = left_lt ? cmd.id : left_entry;
        end
        else if (cmd.rem && !lt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hw/rtl/sorted_id_set_table_unit.sv
// sorted_id_set_table_unit: top level, chain of compare and shift cells plus count and
// response register; depends on sist_pkg and sist_cell
//
// Usage:
//   req channel (req_valid, req_stall, req) carries an operation and an id; rsp channel
//   (rsp_valid, rsp_stall, rsp) returns success, overflow and the entry count after the
//   operation. Exactly one rsp beat per req beat, in order.
//   Every cell compares its entry with the incoming id in the same cycle and shifts left
//   or right by one as the operation needs; the set registers the result of an accepted beat.
//   The response is registered and valid the cycle after the request is taken. Throughput
//   is one beat per cycle while no pending response is held by rsp_stall, set by the single
//   compare/shift pass through the cell row.
//   While rsp_stall holds a pending response, req_stall is raised; a new request is taken
//   in the same cycle the pending response leaves.
//   Reset (rst_n low, asynchronous) empties the set and drops any pending response;
//   no clearing pass is needed, entries past the count are never read.

module sorted_id_set_table_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sist_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sist_pkg::rsp_t rsp
);

    localparam int D = sist_pkg::SET_DEPTH;

    sist_pkg::cnt_t      count_reg;
    sist_pkg::cnt_t      count_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    sist_pkg::rsp_t      rsp_reg;
    sist_pkg::rsp_t      rsp_next;
    sist_pkg::cell_cmd_t cmd;

    sist_pkg::id_t entry_w [D];
    logic [D-1:0]  lt_w;
    logic [D-1:0]  eq_w;
    logic [D-1:0]  use_w;

    logic fire;
    logic hit;
    logic full;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign fire      = req_valid && !req_stall;
    assign hit       = |eq_w;
    assign full      = (count_reg == sist_pkg::CNT_W'(D));

    always_comb
    begin
        cmd.id  = req.bit_id;
        cmd.ins = fire && !hit &&
                  ((req.operation == sist_pkg::OP_SET) || (req.operation == sist_pkg::OP_TOGGLE));
        cmd.rem = fire && hit &&
                  ((req.operation == sist_pkg::OP_CLEAR) || (req.operation == sist_pkg::OP_TOGGLE));
    end

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++)
        begin : g_cell
            logic          l_lt;
            sist_pkg::id_t l_entry;
            sist_pkg::id_t r_entry;

            assign use_w[gi] = (count_reg > sist_pkg::CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign l_lt    = 1'b1;
                assign l_entry = '0;
            end
            else
            begin : g_mid
                assign l_lt    = lt_w[gi-1];
                assign l_entry = entry_w[gi-1];
            end

            if (gi == D - 1)
            begin : g_last
                assign r_entry = '0;
            end
            else
            begin : g_inner
                assign r_entry = entry_w[gi+1];
            end

            sist_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .in_use      (use_w[gi]),
                .left_lt     (l_lt),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .entry       (entry_w[gi]),
                .lt          (lt_w[gi]),
                .eq          (eq_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins && !full)
        begin
            count_next = count_reg + sist_pkg::CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - sist_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next.overflow    = cmd.ins && full;
        rsp_next.entry_count = count_next;
        unique case (req.operation)
            sist_pkg::OP_SET:    rsp_next.success = !hit;
            sist_pkg::OP_CLEAR:  rsp_next.success = hit;
            sist_pkg::OP_TOGGLE: rsp_next.success = 1'b1;
            default:             rsp_next.success = hit;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // held entries must stay strictly ascending
    logic [D-1:0] order_bad;
    always_comb
    begin
        order_bad = '0;
        for (int i = 1; i < D; i++)
        begin
            order_bad[i] = use_w[i] && (entry_w[i-1] >= entry_w[i]);
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sist_pkg::CNT_W'(D))
        else $error("entry count beyond set depth");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        order_bad == '0)
        else $error("set entries out of order or duplicated");

    a_test_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (req.operation == sist_pkg::OP_TEST)) |=> (count_reg == $past(count_reg)))
        else $error("test operation changed the count");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.overflow) |-> (rsp_reg.entry_count == sist_pkg::CNT_W'(D)))
        else $error("overflow reported on a set that is not full");

endmodule
